[hdl/point_projection_to_window_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for point_projection_to_window
// Implication checks on the rising clock edge, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef POINT_PROJECTION_TO_WINDOW_ASSERT_SVH
`define POINT_PROJECTION_TO_WINDOW_ASSERT_SVH

// same-cycle implication
`define PPW_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("ppw: same-cycle check failed");

// next-cycle implication
`define PPW_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("ppw: next-cycle check failed");

`endif

[hdl/ppw_pkg.sv]
// ----------------------------------------------------------------------------
// ppw_pkg
// Types, constants and helpers shared by the point projection block.
// ----------------------------------------------------------------------------
package ppw_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DIV_W     = 32 + FRAC_BITS;      // |clip| << FRAC_BITS
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);
  localparam int NDC_W     = 42;                  // holds +-2^40
  localparam int ACC_W     = 64 - FRAC_BITS + 2;  // sum of four floored terms
  localparam logic [63:0] NDC_LIMIT = 64'd1 << 40;
  localparam logic signed [31:0] ONE_FX = 32'sd1 <<< FRAC_BITS;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  localparam logic [CFG_IDX_W-1:0] REG_VIEWPORT_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VIEWPORT_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VIEWPORT_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VIEWPORT_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SURFACE_HEIGHT  = 3'd4;

  typedef enum logic [1:0] {
    OP_LOAD_MV  = 2'd0,
    OP_LOAD_PJ  = 2'd1,
    OP_PROJECT  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAT,
    S_MNEXT,
    S_DSTART,
    S_DWAIT,
    S_VPX,
    S_VPY,
    S_DONE
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7FFF_FFFF;
    else if (v < -64'sd2147483648) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

[hdl/ppw_if.sv]
// ----------------------------------------------------------------------------
// ppw_req_if / ppw_rsp_if
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface ppw_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [3:0]         entry_index;
  logic signed [31:0] entry_value;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;

  modport source (output valid, op, entry_index, entry_value, point_x, point_y, point_z,
                  input ready);
  modport sink   (input valid, op, entry_index, entry_value, point_x, point_y, point_z,
                  output ready);
endinterface

interface ppw_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] window_x;
  logic signed [31:0] window_y;
  logic signed [31:0] window_depth;
  logic               w_zero;
  logic               visible;

  modport source (output valid, window_x, window_y, window_depth, w_zero, visible,
                  input ready);
  modport sink   (input valid, window_x, window_y, window_depth, w_zero, visible,
                  output ready);
endinterface

[hdl/point_projection_to_window.sv]
// ----------------------------------------------------------------------------
// point_projection_to_window
// Projects an object point through modelview and projection matrices to
// window coordinates, signed Q16.16, with viewport mapping and y inversion.
// ----------------------------------------------------------------------------
// A load word (op 0 modelview, op 1 projection) writes one column-major
// matrix entry. A project word runs two matrix-vector passes, streaming
// the 16 entries out of the matrix store through one 32x32 multiplier;
// then three divisions by clip w on the bit-serial divider, which take
// most of its time; then viewport mapping of x and then of y, and a last
// state that hands off the result word.
// A clip w of zero skips the divisions and returns a zero word with w_zero
// set. Requests are taken only between project words; a finished result sits
// in the output register while the next request is taken. Viewport registers
// are to be written through cfg_write/cfg_index/cfg_data only while the block
// is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module point_projection_to_window (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [ppw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ppw_pkg::CFG_DATA_W-1:0]    cfg_data,
  ppw_req_if.sink                           req,
  ppw_rsp_if.source                         rsp
);
  import ppw_pkg::*;

  `include "point_projection_to_window_assert.svh"

  // configuration
  logic [13:0] viewport_x;
  logic [13:0] viewport_y;
  logic [14:0] viewport_width;
  logic [14:0] viewport_height;
  logic [14:0] surface_height;

  state_t state, state_next;

  logic [4:0]  cnt;        // matrix pass step, 0..17
  logic        pass;       // 0 modelview, 1 projection
  logic [1:0]  div_sel;    // which clip element is being divided

  logic signed [31:0] vec_src [4];
  logic signed [31:0] vec_dst [4];
  logic signed [NDC_W-1:0] ndc [3];

  // matrix stores
  logic        accept;
  logic        mv_we, pj_we;
  logic [3:0]  rd_addr;
  logic signed [31:0] mv_q, pj_q, mat_q;

  // multiply/accumulate pipe
  logic [3:0]  t_rd;
  logic [3:0]  t_mul;
  logic        prod_v;
  logic [3:0]  prod_t;
  logic signed [63:0] prod;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] term;
  logic signed [ACC_W-1:0] acc_sum;

  // divider
  logic        div_start, div_busy, div_done;
  logic signed [NDC_W-1:0] div_q;

  // result staging
  logic signed [31:0] res_x, res_y, res_z;
  logic        res_wz, res_vis;
  logic signed [63:0] vp_prod;
  logic signed [63:0] vp_sum;
  logic signed [63:0] vp_half;
  logic signed [63:0] wz_full;
  logic        mat_last;
  logic        out_free;

  assign accept   = req.valid && req.ready;
  assign mv_we    = accept && (req.op == OP_LOAD_MV);
  assign pj_we    = accept && (req.op == OP_LOAD_PJ);
  assign out_free = !rsp.valid || rsp.ready;

  // term t = row*4 + col, entry address = col*4 + row
  assign t_rd    = cnt[3:0];
  assign rd_addr = {t_rd[1:0], t_rd[3:2]};
  assign t_mul   = 4'(cnt - 5'd1);
  assign mat_q   = pass ? pj_q : mv_q;
  assign mat_last = (cnt == 5'd17);

  ppw_mat_mem u_mv (
    .clk   (clk),
    .rst   (rst),
    .we    (mv_we),
    .waddr (req.entry_index),
    .wdata (req.entry_value),
    .raddr (rd_addr),
    .rdata (mv_q)
  );

  ppw_mat_mem u_pj (
    .clk   (clk),
    .rst   (rst),
    .we    (pj_we),
    .waddr (req.entry_index),
    .wdata (req.entry_value),
    .raddr (rd_addr),
    .rdata (pj_q)
  );

  ppw_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (vec_dst[div_sel]),
    .den   (vec_dst[3]),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_q)
  );

  // config writes; unknown index ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      viewport_x      <= 14'd0;
      viewport_y      <= 14'd0;
      viewport_width  <= 15'd640;
      viewport_height <= 15'd480;
      surface_height  <= 15'd480;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_VIEWPORT_X:      viewport_x      <= cfg_data[13:0];
        REG_VIEWPORT_Y:      viewport_y      <= cfg_data[13:0];
        REG_VIEWPORT_WIDTH:  viewport_width  <= cfg_data;
        REG_VIEWPORT_HEIGHT: viewport_height <= cfg_data;
        REG_SURFACE_HEIGHT:  surface_height  <= cfg_data;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && req.op == OP_PROJECT) state_next = S_MAT;
      end
      S_MAT: begin
        if (mat_last) state_next = S_MNEXT;
      end
      S_MNEXT: begin
        if (!pass) state_next = S_MAT;
        else if (vec_dst[3] == 32'sd0) state_next = S_DONE;
        else state_next = S_DSTART;
      end
      S_DSTART: state_next = S_DWAIT;
      S_DWAIT: begin
        if (div_done) state_next = (div_sel == 2'd2) ? S_VPX : S_DSTART;
      end
      S_VPX: state_next = S_VPY;
      S_VPY: state_next = S_DONE;
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    req.ready = 1'b0;
    div_start = 1'b0;
    unique case (state)
      S_IDLE:   req.ready = 1'b1;
      S_DSTART: div_start = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // floored Q product and running row sum
  assign term    = ACC_W'(prod >>> FRAC_BITS);
  assign acc_sum = (prod_t[1:0] == 2'd0) ? term : (acc + term);

  // viewport mapping: one multiply per axis
  always_comb begin
    vp_prod = 64'sd0;
    if (state == S_VPX) begin
      vp_prod = (64'(ndc[0]) + 64'(ONE_FX)) * $signed({49'd0, viewport_width});
    end else begin
      vp_prod = (64'(ndc[1]) + 64'(ONE_FX)) * $signed({49'd0, viewport_height});
    end
    vp_half = vp_prod >>> 1;
    vp_sum  = 64'sd0;
    if (state == S_VPX) begin
      vp_sum = ($signed({50'd0, viewport_x}) <<< FRAC_BITS) + vp_half;
    end else begin
      vp_sum = ($signed({49'd0, surface_height}) <<< FRAC_BITS)
             - (($signed({50'd0, viewport_y}) <<< FRAC_BITS) + vp_half);
    end
    wz_full = (64'(ndc[2]) + 64'(ONE_FX)) >>> 1;
  end

  // datapath
  always_ff @(posedge clk) begin
    prod   <= 64'(mat_q) * 64'(vec_src[t_mul[1:0]]);
    prod_t <= t_mul;
    if (prod_v) begin
      acc <= acc_sum;
      if (prod_t[1:0] == 2'd3) begin
        vec_dst[prod_t[3:2]] <= sat32(64'(acc_sum));
      end
    end
    case (state)
      S_IDLE: begin
        cnt  <= '0;
        pass <= 1'b0;
        if (accept && req.op == OP_PROJECT) begin
          vec_src[0] <= req.point_x;
          vec_src[1] <= req.point_y;
          vec_src[2] <= req.point_z;
          vec_src[3] <= ONE_FX;
        end
      end
      S_MAT: cnt <= cnt + 5'd1;
      S_MNEXT: begin
        cnt     <= '0;
        pass    <= 1'b1;
        div_sel <= 2'd0;
        vec_src <= vec_dst;
        res_x   <= 32'sd0;
        res_y   <= 32'sd0;
        res_z   <= 32'sd0;
        res_vis <= 1'b0;
        res_wz  <= (vec_dst[3] == 32'sd0);
      end
      S_DWAIT: begin
        if (div_done) begin
          ndc[div_sel] <= div_q;
          div_sel      <= div_sel + 2'd1;
        end
      end
      S_VPX: res_x <= sat32(vp_sum);
      S_VPY: begin
        res_y   <= sat32(vp_sum);
        res_z   <= sat32(wz_full);
        res_vis <= (wz_full <= 64'(ONE_FX));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_v <= 1'b0;
    end else begin
      prod_v <= (state == S_MAT) && (cnt != 5'd0) && (cnt <= 5'd16);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      rsp.window_x     <= res_x;
      rsp.window_y     <= res_y;
      rsp.window_depth <= res_z;
      rsp.w_zero       <= res_wz;
      rsp.visible      <= res_vis;
    end
  end

  `PPW_ASSERT_NXT(a_project_starts, clk, rst, accept && req.op == OP_PROJECT, state == S_MAT)
  `PPW_ASSERT_IMP(a_div_only_waiting, clk, rst, div_busy, state == S_DWAIT)
  `PPW_ASSERT_IMP(a_load_when_idle, clk, rst, mv_we || pj_we, state == S_IDLE && !div_busy)
  `PPW_ASSERT_IMP(a_wzero_clean, clk, rst, rsp.valid && rsp.w_zero, rsp.window_x == 0 && rsp.window_y == 0 && rsp.window_depth == 0 && !rsp.visible)

endmodule

[hdl/ppw_mat_mem.sv]
// ----------------------------------------------------------------------------
// ppw_mat_mem
// 16 x 32 matrix store, one write and one registered read per cycle.
// Entries never written read back as the identity matrix.
// ----------------------------------------------------------------------------
module ppw_mat_mem (
  input  logic               clk,
  input  logic               rst,
  input  logic               we,
  input  logic [3:0]         waddr,
  input  logic signed [31:0] wdata,
  input  logic [3:0]         raddr,
  output logic signed [31:0] rdata
);
  import ppw_pkg::*;

  logic signed [31:0] mem [16];
  logic [15:0]        vld;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (vld[raddr]) begin
      rdata <= mem[raddr];
    end else begin
      // diagonal when row == column
      rdata <= (raddr[1:0] == raddr[3:2]) ? ONE_FX : 32'sd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

endmodule

[hdl/ppw_div.sv]
// ----------------------------------------------------------------------------
// ppw_div
// Restoring divider, one quotient bit per cycle: (num << FRAC_BITS) / den,
// truncated toward zero, clamped to +-2^40.
// ----------------------------------------------------------------------------
module ppw_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [31:0]                num,
  input  logic signed [31:0]                den,
  output logic                              busy,
  output logic                              done,
  output logic signed [ppw_pkg::NDC_W-1:0]  quot
);
  import ppw_pkg::*;

  logic [DIV_CNT_W-1:0] cnt;
  logic [32:0]          rem;
  logic [DIV_W-1:0]     quo;
  logic [31:0]          dmag;
  logic                 neg;

  logic [31:0]          num_mag;
  logic [31:0]          den_mag;
  logic [32:0]          rem_sh;
  logic                 ge;
  logic [32:0]          rem_next;
  logic [DIV_W-1:0]     quo_next;
  logic [63:0]          qlim;

  assign num_mag  = num[31] ? (~num + 32'd1) : num;
  assign den_mag  = den[31] ? (~den + 32'd1) : den;
  assign rem_sh   = {rem[31:0], quo[DIV_W-1]};
  assign ge       = rem_sh >= {1'b0, dmag};
  assign rem_next = ge ? (rem_sh - {1'b0, dmag}) : rem_sh;
  assign quo_next = {quo[DIV_W-2:0], ge};
  assign qlim     = (64'(quo) > NDC_LIMIT) ? NDC_LIMIT : 64'(quo);
  assign quot     = neg ? -$signed(qlim[NDC_W-1:0]) : $signed(qlim[NDC_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo  <= DIV_W'(num_mag) << FRAC_BITS;
      rem  <= '0;
      dmag <= den_mag;
      neg  <= num[31] ^ den[31];
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

endmodule
